>>> rtl/core/mie_pkg.sv
// Shared types for the modular inverse block.
// Command and status words between the controller and the datapath; no dependencies.
package mie_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new word and init the coefficients
    logic div_step;  // one restoring-division / multiply-accumulate step
    logic update;    // close one Euclid iteration and init the next division
    logic out_load;  // write the result register
    logic out_zero;  // force the written result to zero
  } mie_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mod_small;  // current modulus register is 0 or 1
    logic rem_zero;   // remainder of the finished division is zero
  } mie_status_t;

endpackage

>>> rtl/core/modular_inverse_extended_euclid.sv
// Modular inverse by the extended Euclidean method (top level).
// Each word runs CHECK, then one DIVIDE/UPDATE pass per Euclid iteration (at most 46 for
// 32 bits), then FINISH; a modulus of 0 or 1 goes from CHECK straight to FINISH.
// One word is in work at a time; the next can be taken in the cycle after the result is loaded,
// and a stalled result holds the load. Each iteration is WIDTH bit-serial divide steps
// that also build q*s, plus one update step. Rst is synchronous; clears control and valid.
module modular_inverse_extended_euclid import mie_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] value,
  input  logic [31:0] modulus,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] inverse
);

  mie_cmd_t    cmd;
  mie_status_t status;

  mie_control #(.WIDTH(WIDTH)) u_control (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mie_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk     (clk),
    .value   (value),
    .modulus (modulus),
    .cmd     (cmd),
    .status  (status),
    .inverse (inverse)
  );

endmodule

>>> rtl/core/mie_datapath.sv
// Datapath of the modular inverse: remainder sequence, Bezout coefficient, result register.
// Depends on mie_pkg for the command and status words.
module mie_datapath import mie_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic [31:0] value,
  input  logic [31:0] modulus,
  input  mie_cmd_t    cmd,
  output mie_status_t status,
  output logic [31:0] inverse
);

  logic [WIDTH-1:0] a;        // dividend of the current iteration
  logic [WIDTH-1:0] m;        // divisor of the current iteration
  logic [WIDTH-1:0] rem;      // partial remainder
  logic [WIDTH-1:0] dvd;      // dividend bits still to shift in
  logic [WIDTH-1:0] prod;     // q * s_cur, mod 2^WIDTH, built MSB first
  logic [WIDTH-1:0] s_prev;
  logic [WIDTH-1:0] s_cur;
  logic             odd;

  logic [WIDTH-1:0] value_w;
  logic [WIDTH-1:0] modulus_w;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             qbit;
  logic [WIDTH-1:0] result;

  // Inputs reduced to (or extended to) the working width
  assign value_w   = WIDTH'(value);
  assign modulus_w = WIDTH'(modulus);

  // One restoring-division step
  assign shifted = {rem, dvd[WIDTH-1]};
  assign diff    = shifted - {1'b0, m};
  assign qbit    = ~diff[WIDTH];

  // Final coefficient, corrected after an odd number of iterations
  always_comb begin
    if (a == WIDTH'(1)) begin
      result = odd ? (s_prev + s_cur) : s_prev;
    end else begin
      result = '0;
    end
  end

  assign status.mod_small = (m[WIDTH-1:1] == '0);
  assign status.rem_zero  = (rem == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a      <= value_w;
      m      <= modulus_w;
      dvd    <= value_w;
      rem    <= '0;
      prod   <= '0;
      s_prev <= WIDTH'(1);
      s_cur  <= '0;
      odd    <= 1'b0;
    end else if (cmd.div_step) begin
      rem  <= qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd  <= {dvd[WIDTH-2:0], 1'b0};
      prod <= {prod[WIDTH-2:0], 1'b0} + (qbit ? s_cur : '0);
    end else if (cmd.update) begin
      s_prev <= s_cur;
      s_cur  <= s_prev - prod;
      a      <= m;
      m      <= rem;
      dvd    <= m;
      rem    <= '0;
      prod   <= '0;
      odd    <= ~odd;
    end
    // Result register
    if (cmd.out_load) begin
      inverse <= cmd.out_zero ? 32'd0 : 32'(result);
    end
  end

endmodule

>>> rtl/core/mie_control.sv
// Controller of the modular inverse: sequences loads, division steps and result hand-off.
// Depends on mie_pkg for the command and status words.
module mie_control import mie_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  input  mie_status_t status,
  output mie_cmd_t    cmd
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIVIDE,
    UPDATE,
    FINISH
  } state_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  logic           no_inverse;
  logic           out_free;

  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign req_stall = (state != IDLE);

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) & req_valid;
    cmd.div_step = (state == DIVIDE);
    cmd.update   = (state == UPDATE);
    cmd.out_load = (state == FINISH) & out_free;
    cmd.out_zero = no_inverse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cnt        <= '0;
      no_inverse <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // Result word leaves when taken; FINISH refills it in the same cycle
      if (rsp_valid && !rsp_stall && state != FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (status.mod_small) begin
            no_inverse <= 1'b1;
            state      <= FINISH;
          end else begin
            no_inverse <= 1'b0;
            cnt        <= CW'(WIDTH - 1);
            state      <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (cnt == '0) begin
            state <= UPDATE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        UPDATE: begin
          if (status.rem_zero) begin
            state <= FINISH;
          end else begin
            cnt   <= CW'(WIDTH - 1);
            state <= DIVIDE;
          end
        end
        FINISH: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
